// ===== rtl/core/osd_menu_key_controller_macros.svh =====
// Assertion macros shared by the checker of the menu key controller.
`ifndef OSD_MENU_KEY_CONTROLLER_MACROS_SVH
`define OSD_MENU_KEY_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OMKC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("omkc check failed");

// Consequent must hold in the cycle after the antecedent.
`define OMKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("omkc check failed");

`endif

// ===== rtl/core/omkc_pkg.sv =====
// Types and constants shared by the menu key controller modules.
package omkc_pkg;

    // Largest list size the controller handles; the page register holds 128 entries.
    localparam int MAX_ENTRIES   = 128;
    localparam int PAGE_CAPACITY = 128;
    localparam logic [7:0] COUNT_CAP =
        8'((MAX_ENTRIES < PAGE_CAPACITY) ? MAX_ENTRIES : PAGE_CAPACITY);

    // Configuration register indexes.
    localparam logic [1:0] REG_ENTRY_COUNT   = 2'd0;
    localparam logic [1:0] REG_SHOW_DURATION = 2'd1;
    localparam logic [1:0] REG_MAX_ALPHA     = 2'd2;

    localparam logic [7:0] SHOW_DURATION_RESET = 8'd90;
    localparam logic [5:0] MAX_ALPHA_RESET     = 6'd40;
    localparam logic [6:0] ALPHA_STEP_UP       = 7'd4;

    // Key masks, in the bit order of the button levels.
    localparam logic [2:0] KEY_UP   = 3'b001;
    localparam logic [2:0] KEY_OK   = 3'b010;
    localparam logic [2:0] KEY_DOWN = 3'b100;

    // RC5 commands and their toggle memory slots.
    localparam int         IR_TOGGLE_BIT = 11;
    localparam logic [5:0] CMD_UP_A   = 6'd16;
    localparam logic [5:0] CMD_UP_B   = 6'd32;
    localparam logic [5:0] CMD_DOWN_A = 6'd17;
    localparam logic [5:0] CMD_DOWN_B = 6'd33;
    localparam logic [5:0] CMD_OK     = 6'd12;

    localparam int         TOGGLE_SLOTS = 5;
    localparam logic [2:0] SLOT_UP_A    = 3'd0;
    localparam logic [2:0] SLOT_UP_B    = 3'd1;
    localparam logic [2:0] SLOT_DOWN_A  = 3'd2;
    localparam logic [2:0] SLOT_DOWN_B  = 3'd3;
    localparam logic [2:0] SLOT_OK      = 3'd4;
    localparam logic [1:0] TOGGLE_NONE  = 2'd2;

    typedef struct packed {
        logic [2:0]  buttons;
        logic        ir_valid;
        logic [11:0] ir_word;
    } in_beat_t;

    typedef struct packed {
        logic [5:0] alpha;
        logic       visible;
        logic [1:0] cursor_row;
        logic [4:0] cursor_page;
        logic       start_valid;
        logic [6:0] start_index;
    } out_beat_t;

    typedef struct packed {
        logic [4:0] page;
        logic [1:0] row;
    } cursor_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] index;
    } start_req_t;

endpackage

// ===== rtl/core/omkc_cursor.sv =====
// Paged cursor update for one key event: up, then down, then ok.
module omkc_cursor
    import omkc_pkg::*;
(
    input  logic       enable,
    input  logic [2:0] keys,
    input  logic [7:0] count,
    input  cursor_t    cur,
    output cursor_t    cur_next,
    output start_req_t req
);

    logic [5:0] pages;
    logic [4:0] last_page;
    logic [1:0] last_row;

    always_comb begin
        pages     = 6'((9'(count) + 9'd3) >> 2);
        last_page = 5'(pages - 6'd1);
        // Rows on the last page minus one; a full last page wraps to three.
        last_row  = count[1:0] - 2'd1;
        cur_next  = cur;
        req       = '0;
        if (enable) begin
            if ((keys & KEY_UP) != 3'd0) begin
                if (cur_next.row != 2'd0) begin
                    cur_next.row = cur_next.row - 2'd1;
                end else if (cur_next.page != 5'd0) begin
                    cur_next.page = cur_next.page - 5'd1;
                    cur_next.row  = 2'd3;
                end
            end
            if ((keys & KEY_DOWN) != 3'd0) begin
                if (cur_next.page < last_page) begin
                    if (cur_next.row != 2'd3) begin
                        cur_next.row = cur_next.row + 2'd1;
                    end else begin
                        cur_next.page = cur_next.page + 5'd1;
                        cur_next.row  = 2'd0;
                    end
                end else if (cur_next.row < last_row) begin
                    cur_next.row = cur_next.row + 2'd1;
                end
            end
            if ((keys & KEY_OK) != 3'd0) begin
                req.valid = 1'b1;
                req.index = {cur_next.page, cur_next.row};
            end
        end
    end

endmodule

// ===== rtl/core/omkc_fade.sv =====
// Display timer countdown and overlay alpha ramp for one tick.
module omkc_fade
    import omkc_pkg::*;
(
    input  logic       reload,
    input  logic [7:0] show_duration,
    input  logic [5:0] max_alpha,
    input  logic [7:0] timer,
    input  logic [5:0] alpha,
    output logic [7:0] timer_next,
    output logic [5:0] alpha_next
);

    logic [7:0] loaded;
    logic [6:0] raised;

    always_comb begin
        loaded     = reload ? show_duration : timer;
        timer_next = (loaded != 8'd0) ? loaded - 8'd1 : 8'd0;
        raised     = 7'(alpha) + ALPHA_STEP_UP;
        if (timer_next != 8'd0) begin
            alpha_next = (raised > {1'b0, max_alpha}) ? max_alpha : raised[5:0];
        end else if (alpha != 6'd0) begin
            alpha_next = alpha - 6'd1;
        end else begin
            alpha_next = 6'd0;
        end
    end

endmodule

// ===== rtl/core/osd_menu_key_controller.sv =====
// Top level of the on-screen menu key controller.
// Each input beat is one frame tick and yields exactly one result beat. A beat
// is captured in an input register; when the result register is free or being
// read, the whole tick (button edges, RC5 toggle check, cursor moves, timer and
// alpha) is evaluated in one pass and stored in the result register. One beat
// per cycle is sustained while the receiver takes every result; back-pressure
// on m_ready stalls the input register and then s_ready. The state is updated
// as a beat moves from the input register to the result register.
// Configuration writes take effect at once; the user must make them only while
// no tick is in flight, as the block itself does not enforce it.
module osd_menu_key_controller
    import omkc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    logic [7:0] entry_count_reg;
    logic [7:0] show_duration_reg;
    logic [5:0] max_alpha_reg;

    logic       in_valid_reg;
    in_beat_t   in_data_reg;
    logic       out_valid_reg;
    out_beat_t  out_data_reg;

    logic [2:0] last_buttons_reg;
    logic [1:0] toggle_mem_reg [TOGGLE_SLOTS];
    cursor_t    cursor_reg;
    logic [7:0] show_timer_reg;
    logic [5:0] alpha_reg;

    logic       advance;
    logic [7:0] count_eff;
    logic       active;
    logic [2:0] fresh;
    logic       btn_event;
    logic       ir_hit;
    logic [2:0] ir_slot;
    logic [2:0] ir_keys;
    logic [1:0] ir_toggle;
    logic       ir_event;
    cursor_t    cursor_btn;
    cursor_t    cursor_next;
    start_req_t req_btn;
    start_req_t req_ir;
    logic [7:0] show_timer_next;
    logic [5:0] alpha_next;
    out_beat_t  out_data_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign count_eff = (entry_count_reg > COUNT_CAP) ? COUNT_CAP : entry_count_reg;
    assign active    = (alpha_reg != 6'd0) && (count_eff != 8'd0);
    assign fresh     = in_data_reg.buttons & ~last_buttons_reg;
    assign btn_event = fresh != 3'd0;
    assign ir_toggle = {1'b0, in_data_reg.ir_word[IR_TOGGLE_BIT]};

    always_comb begin
        ir_hit  = 1'b0;
        ir_slot = SLOT_UP_A;
        ir_keys = 3'd0;
        if (in_data_reg.ir_valid) begin
            case (in_data_reg.ir_word[5:0])
                CMD_UP_A: begin
                    ir_hit = 1'b1; ir_slot = SLOT_UP_A; ir_keys = KEY_UP;
                end
                CMD_UP_B: begin
                    ir_hit = 1'b1; ir_slot = SLOT_UP_B; ir_keys = KEY_UP;
                end
                CMD_DOWN_A: begin
                    ir_hit = 1'b1; ir_slot = SLOT_DOWN_A; ir_keys = KEY_DOWN;
                end
                CMD_DOWN_B: begin
                    ir_hit = 1'b1; ir_slot = SLOT_DOWN_B; ir_keys = KEY_DOWN;
                end
                CMD_OK: begin
                    ir_hit = 1'b1; ir_slot = SLOT_OK; ir_keys = KEY_OK;
                end
                default: begin
                    ir_hit = 1'b0;
                end
            endcase
        end
    end

    // A repeated RC5 frame carries the same toggle as the one stored for its command.
    assign ir_event = ir_hit && (toggle_mem_reg[ir_slot] != ir_toggle);

    omkc_cursor u_cursor_btn (
        .enable   (btn_event && active),
        .keys     (fresh),
        .count    (count_eff),
        .cur      (cursor_reg),
        .cur_next (cursor_btn),
        .req      (req_btn)
    );

    omkc_cursor u_cursor_ir (
        .enable   (ir_event && active),
        .keys     (ir_keys),
        .count    (count_eff),
        .cur      (cursor_btn),
        .cur_next (cursor_next),
        .req      (req_ir)
    );

    omkc_fade u_fade (
        .reload        (btn_event || ir_event),
        .show_duration (show_duration_reg),
        .max_alpha     (max_alpha_reg),
        .timer         (show_timer_reg),
        .alpha         (alpha_reg),
        .timer_next    (show_timer_next),
        .alpha_next    (alpha_next)
    );

    always_comb begin
        out_data_next.alpha       = alpha_next;
        out_data_next.visible     = alpha_next != 6'd0;
        out_data_next.cursor_row  = cursor_next.row;
        out_data_next.cursor_page = cursor_next.page;
        out_data_next.start_valid = req_btn.valid || req_ir.valid;
        out_data_next.start_index = req_ir.valid ? req_ir.index : req_btn.index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg   <= 8'd0;
            show_duration_reg <= SHOW_DURATION_RESET;
            max_alpha_reg     <= MAX_ALPHA_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENTRY_COUNT:   entry_count_reg   <= cfg_data;
                REG_SHOW_DURATION: show_duration_reg <= cfg_data;
                REG_MAX_ALPHA:     max_alpha_reg     <= cfg_data[5:0];
                default:           entry_count_reg   <= entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_buttons_reg <= 3'd0;
            for (int i = 0; i < TOGGLE_SLOTS; i++) begin
                toggle_mem_reg[i] <= TOGGLE_NONE;
            end
            cursor_reg       <= '0;
            show_timer_reg   <= SHOW_DURATION_RESET;
            alpha_reg        <= 6'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                last_buttons_reg <= in_data_reg.buttons;
                if (ir_event) begin
                    toggle_mem_reg[ir_slot] <= ir_toggle;
                end
                cursor_reg       <= cursor_next;
                show_timer_reg   <= show_timer_next;
                alpha_reg        <= alpha_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/core/omkc_checker.sv =====
// Port-level checks of the menu key controller, bound to its top level.
`include "osd_menu_key_controller_macros.svh"

module omkc_checker
    import omkc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `OMKC_ASSERT_NOW(a_visible_alpha, m_valid, m_data.visible == (m_data.alpha != 6'd0))
    `OMKC_ASSERT_NOW(a_idle_index, m_valid && !m_data.start_valid, m_data.start_index == 7'd0)
    `OMKC_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))
    `OMKC_ASSERT_NOW(a_no_result_after_reset, $past(!aresetn), !m_valid)

endmodule

bind osd_menu_key_controller omkc_checker u_omkc_checker (.*);

// ===== tb/omkc_tick_checker.sv =====
// Predictor and scoreboard that checks each result beat of the menu key controller.
`timescale 1ns / 1ps
module omkc_tick_checker
    import omkc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fail_count,
    output int        outstanding,
    output int        ticks_checked,
    output int        starts_seen
);

    localparam logic [1:0] ROW_LAST  = 2'd3;

    // Shadow copy of the register settings.
    logic [7:0] cfg_entries;
    logic [7:0] cfg_duration;
    logic [5:0] cfg_alpha_max;

    // Shadow copy of the menu state.
    logic [2:0] prev_buttons;
    logic [1:0] toggle_seen [TOGGLE_SLOTS];
    logic [1:0] row_q;
    logic [4:0] page_q;
    logic [7:0] timer_q;
    logic [5:0] alpha_q;
    logic       start_req;
    logic [6:0] start_idx;

    out_beat_t expected_ticks [$];
    out_beat_t predicted;
    out_beat_t oldest;

    task automatic apply_key(input logic [2:0] keys);
        logic [7:0] n;
        int         last_page;
        int         last_rows;
        timer_q = cfg_duration;
        if (alpha_q == 6'd0)
            return;
        n = (cfg_entries > COUNT_CAP) ? COUNT_CAP : cfg_entries;
        if (n == 8'd0)
            return;
        last_page = (int'(n) + 3) / 4 - 1;
        last_rows = int'(n) % 4;
        if (last_rows == 0)
            last_rows = 4;

        if ((keys & KEY_UP) != 3'b000) begin
            if (row_q > 2'd0) begin
                row_q = row_q - 2'd1;
            end else if (page_q > 5'd0) begin
                page_q = page_q - 5'd1;
                row_q  = ROW_LAST;
            end
        end
        if ((keys & KEY_DOWN) != 3'b000) begin
            if (int'(page_q) < last_page) begin
                if (row_q < ROW_LAST) begin
                    row_q = row_q + 2'd1;
                end else begin
                    page_q = page_q + 5'd1;
                    row_q  = 2'd0;
                end
            end else if (int'(row_q) < last_rows - 1) begin
                row_q = row_q + 2'd1;
            end
        end
        if ((keys & KEY_OK) != 3'b000) begin
            start_req = 1'b1;
            start_idx = {page_q, row_q};
        end
    endtask

    // An RC5 command only counts when its toggle differs from the one last seen for it.
    task automatic ir_command(input logic [2:0] slot, input logic tog, input logic [2:0] keys);
        if (toggle_seen[slot] != {1'b0, tog}) begin
            toggle_seen[slot] = {1'b0, tog};
            apply_key(keys);
        end
    endtask

    task automatic advance_menu_tick(input in_beat_t beat, output out_beat_t res);
        logic [2:0] fresh;
        logic       tog;
        int         raised;
        start_req = 1'b0;
        start_idx = 7'd0;

        fresh = beat.buttons & ~prev_buttons;
        prev_buttons = beat.buttons;
        if (fresh != 3'b000)
            apply_key(fresh);

        tog = beat.ir_word[IR_TOGGLE_BIT];
        if (beat.ir_valid) begin
            case (beat.ir_word[5:0])
                CMD_UP_A:   ir_command(SLOT_UP_A, tog, KEY_UP);
                CMD_UP_B:   ir_command(SLOT_UP_B, tog, KEY_UP);
                CMD_DOWN_A: ir_command(SLOT_DOWN_A, tog, KEY_DOWN);
                CMD_DOWN_B: ir_command(SLOT_DOWN_B, tog, KEY_DOWN);
                CMD_OK:     ir_command(SLOT_OK, tog, KEY_OK);
                default:    ;
            endcase
        end

        if (timer_q > 8'd0)
            timer_q = timer_q - 8'd1;
        if (timer_q > 8'd0) begin
            raised  = int'(alpha_q) + int'(ALPHA_STEP_UP);
            alpha_q = (raised > int'(cfg_alpha_max)) ? cfg_alpha_max : 6'(raised);
        end else if (alpha_q > 6'd0) begin
            alpha_q = alpha_q - 6'd1;
        end

        res.alpha       = alpha_q;
        res.visible     = (alpha_q != 6'd0);
        res.cursor_row  = row_q;
        res.cursor_page = page_q;
        res.start_valid = start_req;
        res.start_index = start_idx;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_entries   = 8'd0;
            cfg_duration  = SHOW_DURATION_RESET;
            cfg_alpha_max = MAX_ALPHA_RESET;
            prev_buttons  = 3'b000;
            for (int i = 0; i < TOGGLE_SLOTS; i++)
                toggle_seen[i] = TOGGLE_NONE;
            row_q   = 2'd0;
            page_q  = 5'd0;
            timer_q = SHOW_DURATION_RESET;
            alpha_q = 6'd0;
            expected_ticks.delete();
            fail_count    = 0;
            ticks_checked = 0;
            starts_seen   = 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ENTRY_COUNT:   cfg_entries   = cfg_data;
                    REG_SHOW_DURATION: cfg_duration  = cfg_data;
                    REG_MAX_ALPHA:     cfg_alpha_max = cfg_data[5:0];
                    default:           ;
                endcase
            end

            if (s_valid && s_ready) begin
                advance_menu_tick(s_data, predicted);
                expected_ticks.push_back(predicted);
            end

            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    fail_count++;
                    $display("[%0t] result beat with no tick pending: expected none, actual %h",
                             $time, m_data);
                end else begin
                    oldest = expected_ticks.pop_front();
                    check_field("alpha", oldest.alpha, m_data.alpha);
                    check_field("visible", oldest.visible, m_data.visible);
                    check_field("cursor_row", oldest.cursor_row, m_data.cursor_row);
                    check_field("cursor_page", oldest.cursor_page, m_data.cursor_page);
                    check_field("start_valid", oldest.start_valid, m_data.start_valid);
                    check_field("start_index", oldest.start_index, m_data.start_index);
                    ticks_checked++;
                    if (oldest.start_valid)
                        starts_seen++;
                end
            end

            outstanding <= expected_ticks.size();
        end
    end

endmodule

// ===== tb/tb_osd_menu_key_controller.sv =====
// Stimulus and verdict for the menu key controller testbench.
`timescale 1ns / 1ps
module tb_osd_menu_key_controller;
    import omkc_pkg::*;

    localparam int IDLE_PCT       = 35;
    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    in_beat_t   s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;

    int fail_count;
    int outstanding;
    int ticks_checked;
    int starts_seen;

    bit         burst = 1'b0;
    bit         stall_req = 1'b0;
    bit         stall_done = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         settings_used = 0;
    logic [2:0] held_buttons = 3'b000;
    bit         toggle_sent [TOGGLE_SLOTS];

    always #6 aclk = ~aclk;

    osd_menu_key_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    omkc_tick_checker u_tick_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .ticks_checked (ticks_checked),
        .starts_seen   (starts_seen)
    );

    // Receiver: random back-pressure, one long hold-off on request, none in burst mode.
    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left  <= STALL_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (burst) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic in_beat_t tick_of(logic [2:0] btn, logic irv, logic [11:0] word);
        in_beat_t beat;
        beat.buttons  = btn;
        beat.ir_valid = irv;
        beat.ir_word  = word;
        return beat;
    endfunction

    task automatic send_item(input in_beat_t beat);
        while (!burst && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every tick has produced its result, then let the pipeline drain.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [7:0] entries, input logic [7:0] duration,
                                  input logic [5:0] alpha_max);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= entries;
        @(posedge aclk);
        cfg_index <= REG_SHOW_DURATION;
        cfg_data  <= duration;
        @(posedge aclk);
        cfg_index <= REG_MAX_ALPHA;
        cfg_data  <= {2'b00, alpha_max};
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Quiet ticks release buttons and at times resend an OK frame with its last toggle,
    // so the overlay can time out; active ticks mostly carry RC5 commands with a fresh toggle, steered by down_pct.
    task automatic build_tick(input int key_rate, input int down_pct, output in_beat_t beat);
        int         pick;
        int         dir;
        logic [2:0] slot;
        beat.buttons  = held_buttons;
        beat.ir_valid = 1'b0;
        beat.ir_word  = 12'($urandom);
        if ($urandom_range(99) >= key_rate) begin
            beat.buttons = held_buttons & 3'($urandom);
            if ($urandom_range(7) == 0) begin
                beat.ir_valid = 1'b1;
                beat.ir_word[5:0] = CMD_OK;
                beat.ir_word[IR_TOGGLE_BIT] = toggle_sent[SLOT_OK];
            end
        end else begin
            pick = $urandom_range(9);
            if (pick <= 5) begin
                dir = $urandom_range(99);
                if (dir < down_pct)
                    slot = $urandom_range(1) ? SLOT_DOWN_B : SLOT_DOWN_A;
                else if (dir < down_pct + 12)
                    slot = SLOT_OK;
                else
                    slot = $urandom_range(1) ? SLOT_UP_B : SLOT_UP_A;
                case (slot)
                    SLOT_UP_A:   beat.ir_word[5:0] = CMD_UP_A;
                    SLOT_UP_B:   beat.ir_word[5:0] = CMD_UP_B;
                    SLOT_DOWN_A: beat.ir_word[5:0] = CMD_DOWN_A;
                    SLOT_DOWN_B: beat.ir_word[5:0] = CMD_DOWN_B;
                    default:     beat.ir_word[5:0] = CMD_OK;
                endcase
                if ($urandom_range(99) < 80)
                    toggle_sent[slot] = ~toggle_sent[slot];
                beat.ir_word[IR_TOGGLE_BIT] = toggle_sent[slot];
                beat.ir_valid = 1'b1;
                if ($urandom_range(4) == 0)
                    beat.buttons = 3'($urandom);
            end else if (pick <= 8) begin
                beat.buttons = 3'($urandom);
            end else begin
                beat.ir_valid = 1'b1;
            end
        end
        held_buttons = beat.buttons;
    endtask

    task automatic run_phase(input logic [7:0] entries, input logic [7:0] duration,
                             input logic [5:0] alpha_max, input int n_items,
                             input int key_rate, input int down_pct,
                             input bit no_idle, input int stall_at);
        in_beat_t beat;
        write_settings(entries, duration, alpha_max);
        burst <= no_idle;
        for (int i = 0; i < n_items; i++) begin
            if (i == stall_at)
                stall_req <= 1'b1;
            build_tick(key_rate, down_pct, beat);
            send_item(beat);
        end
    endtask

    initial begin
        for (int i = 0; i < TOGGLE_SLOTS; i++)
            toggle_sent[i] = 1'b0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= 8'd0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: no entries, so keys only reload the timer.
        send_item(tick_of(3'b111, 1'b1, {1'b0, 5'h00, CMD_OK}));
        send_item(tick_of(3'b000, 1'b0, 12'hFFF));
        send_item(tick_of(KEY_DOWN, 1'b1, {1'b1, 5'h1F, CMD_DOWN_A}));
        send_item(tick_of(KEY_OK, 1'b1, {1'b0, 5'h00, CMD_UP_A}));

        // Six entries: two pages, two rows on the last one.
        write_settings(8'd6, 8'd255, 6'd63);
        send_item(tick_of(KEY_DOWN, 1'b0, 12'h000));
        send_item(tick_of(3'b000, 1'b1, {1'b1, 5'h00, CMD_DOWN_A}));
        send_item(tick_of(3'b000, 1'b1, {1'b0, 5'h00, CMD_DOWN_B}));
        send_item(tick_of(3'b000, 1'b1, {1'b0, 5'h15, CMD_DOWN_B}));
        send_item(tick_of(3'b000, 1'b1, {1'b0, 5'h00, CMD_DOWN_A}));
        send_item(tick_of(KEY_DOWN, 1'b1, {1'b0, 5'h0A, CMD_DOWN_A}));
        send_item(tick_of(KEY_OK | KEY_DOWN, 1'b1, {1'b1, 5'h00, CMD_OK}));
        send_item(tick_of(3'b000, 1'b1, {1'b1, 5'h00, CMD_UP_A}));
        send_item(tick_of(3'b000, 1'b1, {1'b1, 5'h00, CMD_UP_B}));
        send_item(tick_of(KEY_UP, 1'b1, {1'b0, 5'h1F, 6'h3F}));
        send_item(tick_of(3'b111, 1'b1, 12'hFFF));
        send_item(tick_of(3'b000, 1'b1, {1'b0, 5'h00, CMD_UP_A}));
        send_item(tick_of(KEY_OK, 1'b1, {1'b0, 5'h00, CMD_OK}));

        // Full list walked down hard, with one long receiver hold-off.
        run_phase(8'd128, 8'd255, 6'd63, 300, 90, 85, 1'b0, 40);
        // Count and opacity limit lowered under the cursor, no idling on either side.
        run_phase(8'd4, 8'd20, 6'd12, 150, 60, 20, 1'b1, -1);
        run_phase(8'd1, 8'd1, 6'd5, 100, 70, 30, 1'b0, -1);
        // Count beyond the page capacity, short display time so the overlay fades.
        run_phase(8'd255, 8'd3, 6'd63, 120, 25, 50, 1'b0, -1);
        run_phase(8'd5, 8'd0, 6'd40, 80, 40, 50, 1'b0, -1);
        run_phase(8'd0, 8'd90, 6'd0, 60, 60, 50, 1'b0, -1);
        repeat (4)
            run_phase(8'($urandom_range(0, 140)), 8'($urandom_range(0, 60)), 6'($urandom),
                      110, $urandom_range(20, 90), $urandom_range(10, 90), 1'b0, -1);

        settle();
        $display("Checked %0d frame ticks over %0d register settings, %0d with a start request.",
                 ticks_checked, settings_used, starts_seen);
        $display("Included a %0d-cycle receiver hold-off and an idle-free burst phase.",
                 STALL_CYCLES);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/omkc_pkg.sv
rtl/core/omkc_cursor.sv
rtl/core/omkc_fade.sv
rtl/core/osd_menu_key_controller.sv
rtl/core/omkc_checker.sv
tb/omkc_tick_checker.sv
tb/tb_osd_menu_key_controller.sv
